@@ rtl/fractal_gradient_noise_2d_macros.svh @@
// assertion macros for the fractal gradient noise block
`ifndef FRACTAL_GRADIENT_NOISE_2D_MACROS_SVH
`define FRACTAL_GRADIENT_NOISE_2D_MACROS_SVH

// same-cycle implication
`define FGN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FGN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fgn_pkg.sv @@
// types, constants and helper functions for the fractal gradient noise block
`default_nettype none
package fgn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TABLE_SIZE = 256;
  localparam int AMP_W = 19;
  localparam int FREQ_W = 24;
  localparam int PERS_W = 17;
  localparam int LAC_W = 20;
  localparam int OCT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WT_W = 37;
  localparam int Q_W = 17;

  localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_AMPLITUDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 3'd4;

  localparam logic [OCT_W-1:0] OCT_RESET = 4'd1;
  localparam logic [PERS_W-1:0] PERS_RESET = 17'd32768;
  localparam logic [LAC_W-1:0] LAC_RESET = 20'd131072;
  localparam logic [AMP_W-1:0] AMP_RESET = 19'd65536;
  localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;

  localparam logic [7:0] PERM_TAB [TABLE_SIZE] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // dot product of one of eight gradients with a corner offset
  function automatic logic signed [18:0] grad_dot(input logic [2:0] g,
                                                  input logic signed [17:0] ox,
                                                  input logic signed [17:0] oy);
    logic signed [18:0] x;
    logic signed [18:0] y;
    logic signed [18:0] r;
    x = 19'(ox);
    y = 19'(oy);
    case (g)
      3'd0: r = x + y;
      3'd1: r = y - x;
      3'd2: r = x - y;
      3'd3: r = -x - y;
      3'd4: r = x;
      3'd5: r = -x;
      3'd6: r = y;
      default: r = -y;
    endcase
    return r;
  endfunction

  // a + floor(t * (b - a) / 2^16)
  function automatic logic signed [19:0] lerp_fx(input logic signed [19:0] a,
                                                 input logic signed [19:0] b,
                                                 input logic [16:0] t);
    logic signed [20:0] d;
    logic signed [38:0] p;
    logic signed [38:0] r;
    d = 21'(b) - 21'(a);
    p = 39'($signed({1'b0, t})) * 39'(d);
    r = 39'(a) + (p >>> FRAC_BITS);
    return r[19:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/fgn_if.sv @@
// handshake channel interfaces for the fractal gradient noise block
`default_nettype none
interface fgn_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface fgn_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

interface fgn_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/fractal_gradient_noise_2d.sv @@
// pipeline of 7 octave lane stages, sum, magnitude, 17 divider stages and output
// register; throughput one word per cycle while the output is accepted and no table pass runs
// synchronous active-low reset clears control and config to defaults, then a
// pass recomputes per-octave amplitude and frequency;
// the same pass follows every config write and holds input ready low meanwhile
`default_nettype none
`include "fractal_gradient_noise_2d_macros.svh"
module fractal_gradient_noise_2d import fgn_pkg::*; #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  fgn_cfg_if.sink       cfg_ch,
  fgn_in_if.sink        in_ch,
  fgn_out_if.source     out_ch
);

  localparam int IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int LG_W = $clog2(MAX_OCTAVES) + 1;
  localparam int TOT_W = WT_W + LG_W;
  localparam int ASUM_W = AMP_W + LG_W;
  localparam int DIV_W = ASUM_W + 1;
  localparam int REM_W = (TOT_W > DIV_W + Q_W - 1) ? TOT_W : DIV_W + Q_W - 1;
  localparam int NST = 9 + Q_W;

  typedef enum logic [2:0] {
    PRE_LOAD = 3'b001,
    PRE_RUN  = 3'b010,
    PRE_DONE = 3'b100
  } pre_state_t;

  // config registers
  logic [OCT_W-1:0] oct_r;
  logic [PERS_W-1:0] pers_r;
  logic [LAC_W-1:0] lac_r;
  logic [AMP_W-1:0] bamp_r;
  logic [FREQ_W-1:0] bfreq_r;
  logic cfg_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid & cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_r <= OCT_RESET;
      pers_r <= PERS_RESET;
      lac_r <= LAC_RESET;
      bamp_r <= AMP_RESET;
      bfreq_r <= FREQ_RESET;
    end else if (cfg_wr) begin
      case (cfg_ch.index)
        REG_OCTAVE_COUNT: oct_r <= cfg_ch.data[OCT_W-1:0];
        REG_PERSISTENCE: pers_r <= cfg_ch.data[PERS_W-1:0];
        REG_LACUNARITY: lac_r <= cfg_ch.data[LAC_W-1:0];
        REG_BASE_AMPLITUDE: bamp_r <= cfg_ch.data[AMP_W-1:0];
        REG_BASE_FREQUENCY: bfreq_r <= cfg_ch.data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // per-octave amplitude and frequency table
  pre_state_t pre_state_r, pre_state_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [AMP_W-1:0] cur_amp_r;
  logic [FREQ_W-1:0] cur_freq_r;
  logic [AMP_W-1:0] amp_r [MAX_OCTAVES];
  logic [FREQ_W-1:0] freq_r [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] on_r;
  logic [ASUM_W-1:0] asum_r;
  logic [35:0] amp_prod;
  logic [43:0] freq_prod;
  logic [AMP_W-1:0] amp_nxt;
  logic [FREQ_W-1:0] freq_nxt;
  logic idx_on;
  logic idx_last;

  always_comb begin
    amp_prod = 36'(cur_amp_r) * 36'(pers_r);
    freq_prod = 44'(cur_freq_r) * 44'(lac_r);
    amp_nxt = (amp_prod[35:FRAC_BITS] > 20'(AMP_MAX)) ? AMP_MAX
                                                       : amp_prod[FRAC_BITS+AMP_W-1:FRAC_BITS];
    freq_nxt = (freq_prod[43:FRAC_BITS] > 28'(FREQ_MAX)) ? FREQ_MAX
                                                          : freq_prod[FRAC_BITS+FREQ_W-1:FRAC_BITS];
    idx_on = 5'(idx_r) < 5'(oct_r);
    idx_last = 32'(idx_r) == 32'(MAX_OCTAVES - 1);
    pre_state_nxt = pre_state_r;
    case (pre_state_r)
      PRE_LOAD: pre_state_nxt = PRE_RUN;
      PRE_RUN: if (idx_last) pre_state_nxt = PRE_DONE;
      PRE_DONE: pre_state_nxt = PRE_DONE;
      default: pre_state_nxt = PRE_LOAD;
    endcase
    if (cfg_wr) pre_state_nxt = PRE_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_state_r <= PRE_LOAD;
      idx_r <= '0;
      asum_r <= '0;
      on_r <= '0;
    end else begin
      pre_state_r <= pre_state_nxt;
      if (pre_state_r == PRE_LOAD) begin
        idx_r <= '0;
        asum_r <= '0;
      end else if (pre_state_r == PRE_RUN) begin
        on_r[idx_r] <= idx_on;
        if (idx_on) asum_r <= asum_r + ASUM_W'(cur_amp_r);
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pre_state_r == PRE_LOAD) begin
      cur_amp_r <= bamp_r;
      cur_freq_r <= bfreq_r;
    end else if (pre_state_r == PRE_RUN) begin
      amp_r[idx_r] <= cur_amp_r;
      freq_r[idx_r] <= cur_freq_r;
      cur_amp_r <= amp_nxt;
      cur_freq_r <= freq_nxt;
    end
  end

  // pipeline control
  logic adv;
  logic in_acc;
  logic [NST-1:0] vld_r;
  logic out_vld_r;
  logic signed [15:0] out_val_r;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && (pre_state_r == PRE_DONE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.noise_value = out_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_acc};
      out_vld_r <= vld_r[NST-1];
    end
  end

  // octave lanes
  logic signed [WT_W-1:0] wt_lane [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
    logic signed [56:0] mx, my;
    logic [23:0] s1_x_r, s1_y_r;
    logic [15:0] s2_u_r, s2_v_r, s2_squ_r, s2_sqv_r;
    logic [7:0] s2_px0_r, s2_px1_r, s2_y0_r;
    logic [31:0] squ, sqv;
    logic [7:0] ha, hb, hc, hd;
    logic [33:0] fpu, fpv;
    logic [2:0] s3_ga_r, s3_gb_r, s3_gc_r, s3_gd_r;
    logic [15:0] s3_u_r, s3_v_r;
    logic [16:0] s3_fu_r, s3_fv_r;
    logic signed [17:0] ou0, ou1, ov0, ov1;
    logic signed [18:0] s4_da_r, s4_db_r, s4_dc_r, s4_dd_r;
    logic [16:0] s4_fu_r, s4_fv_r, s5_fv_r;
    logic signed [19:0] s5_bot_r, s5_top_r, lv;
    logic signed [17:0] s6_val_r, vcl;
    logic signed [WT_W-1:0] s7_wt_r;

    always_comb begin
      mx = 57'(in_ch.x_coord) * 57'($signed({1'b0, freq_r[i]}));
      my = 57'(in_ch.y_coord) * 57'($signed({1'b0, freq_r[i]}));
      squ = 32'(s1_x_r[15:0]) * 32'(s1_x_r[15:0]);
      sqv = 32'(s1_y_r[15:0]) * 32'(s1_y_r[15:0]);
      ha = PERM_TAB[s2_px0_r + s2_y0_r];
      hb = PERM_TAB[s2_px1_r + s2_y0_r];
      hc = PERM_TAB[s2_px0_r + s2_y0_r + 8'd1];
      hd = PERM_TAB[s2_px1_r + s2_y0_r + 8'd1];
      fpu = 34'(s2_squ_r) * 34'(18'd196608 - {1'b0, s2_u_r, 1'b0});
      fpv = 34'(s2_sqv_r) * 34'(18'd196608 - {1'b0, s2_v_r, 1'b0});
      ou0 = $signed({2'b00, s3_u_r});
      ov0 = $signed({2'b00, s3_v_r});
      ou1 = ou0 - 18'sd65536;
      ov1 = ov0 - 18'sd65536;
      lv = lerp_fx(s5_bot_r, s5_top_r, s5_fv_r);
      if (lv > 20'sd65536) vcl = 18'sd65536;
      else if (lv < -20'sd65536) vcl = -18'sd65536;
      else vcl = lv[17:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        s1_x_r <= mx[2*FRAC_BITS+7:FRAC_BITS];
        s1_y_r <= my[2*FRAC_BITS+7:FRAC_BITS];
        s2_u_r <= s1_x_r[15:0];
        s2_v_r <= s1_y_r[15:0];
        s2_squ_r <= squ[31:16];
        s2_sqv_r <= sqv[31:16];
        s2_px0_r <= PERM_TAB[s1_x_r[23:16]];
        s2_px1_r <= PERM_TAB[s1_x_r[23:16] + 8'd1];
        s2_y0_r <= s1_y_r[23:16];
        s3_ga_r <= ha[2:0];
        s3_gb_r <= hb[2:0];
        s3_gc_r <= hc[2:0];
        s3_gd_r <= hd[2:0];
        s3_u_r <= s2_u_r;
        s3_v_r <= s2_v_r;
        s3_fu_r <= fpu[32:16];
        s3_fv_r <= fpv[32:16];
        s4_da_r <= grad_dot(s3_ga_r, ou0, ov0);
        s4_db_r <= grad_dot(s3_gb_r, ou1, ov0);
        s4_dc_r <= grad_dot(s3_gc_r, ou0, ov1);
        s4_dd_r <= grad_dot(s3_gd_r, ou1, ov1);
        s4_fu_r <= s3_fu_r;
        s4_fv_r <= s3_fv_r;
        s5_bot_r <= lerp_fx(20'(s4_da_r), 20'(s4_db_r), s4_fu_r);
        s5_top_r <= lerp_fx(20'(s4_dc_r), 20'(s4_dd_r), s4_fu_r);
        s5_fv_r <= s4_fv_r;
        s6_val_r <= vcl;
        s7_wt_r <= on_r[i] ? WT_W'(s6_val_r) * WT_W'($signed({1'b0, amp_r[i]}))
                           : '0;
      end
    end

    assign wt_lane[i] = s7_wt_r;
  end

  // sum, magnitude and division by twice the amplitude sum
  logic signed [TOT_W-1:0] tot_sum;
  logic signed [TOT_W-1:0] tot_r;
  logic neg_r;
  logic [REM_W-1:0] mag_r;
  logic [REM_W-1:0] drem_r [Q_W];
  logic [Q_W-1:0] dq_r [Q_W];
  logic dneg_r [Q_W];

  always_comb begin
    tot_sum = '0;
    for (int k = 0; k < MAX_OCTAVES; k++) tot_sum = tot_sum + TOT_W'(wt_lane[k]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tot_r <= tot_sum;
      neg_r <= tot_r < 0;
      mag_r <= (tot_r < 0) ? REM_W'(-tot_r) : REM_W'(tot_r);
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [REM_W-1:0] dsr;
    logic [REM_W-1:0] rin;
    logic [Q_W-1:0] qin;
    logic nin;
    logic ge;

    if (k == 0) begin : g_first
      assign rin = mag_r;
      assign qin = '0;
      assign nin = neg_r;
    end else begin : g_next
      assign rin = drem_r[k-1];
      assign qin = dq_r[k-1];
      assign nin = dneg_r[k-1];
    end

    assign dsr = REM_W'({asum_r, 1'b0}) << (Q_W - 1 - k);
    assign ge = rin >= dsr;

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[k] <= ge ? rin - dsr : rin;
        dq_r[k] <= {qin[Q_W-2:0], ge};
        dneg_r[k] <= nin;
      end
    end
  end

  logic [Q_W-1:0] qf;
  logic signed [15:0] res;

  always_comb begin
    qf = dq_r[Q_W-1];
    if (asum_r == '0) res = '0;
    else if (dneg_r[Q_W-1]) res = 16'(-qf);
    else if (qf > 17'd32767) res = 16'sd32767;
    else res = qf[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[NST-1]) out_val_r <= res;
  end

  `FGN_ASSERT_IMP(a_in_after_table, in_ch.valid && in_ch.ready, pre_state_r == PRE_DONE, "input taken while octave table rebuilds")
  `FGN_ASSERT_NXT(a_cfg_blocks_in, cfg_ch.valid && cfg_ch.ready, !in_ch.ready, "input ready right after config write")
  `FGN_ASSERT_IMP(a_zero_sum, out_ch.valid && (asum_r == '0), out_ch.noise_value == 16'sd0, "nonzero word with zero amplitude sum")

endmodule
`default_nettype wire

@@ bench/fractal_gradient_noise_2d_test.sv @@
// self-checking testbench for the fractal gradient noise block
`default_nettype none
module fractal_gradient_noise_2d_test import fgn_pkg::*;;

  logic clk;
  logic rst_n;
  fgn_cfg_if cfg_ch();
  fgn_in_if in_ch();
  fgn_out_if out_ch();

  fractal_gradient_noise_2d dut (
    .clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .in_ch(in_ch), .out_ch(out_ch)
  );

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  localparam int GRAD_X [8] = '{1, -1, 1, -1, 1, -1, 0, 0};
  localparam int GRAD_Y [8] = '{1, 1, -1, -1, 0, 0, 1, -1};

  point_t point_q[$];
  logic signed [15:0] noise_q[$];
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_trigger = 0;
  bit hold_done = 0;
  bit calm = 0;

  logic [OCT_W-1:0] octaves;
  logic [PERS_W-1:0] pers;
  logic [LAC_W-1:0] lac;
  logic [AMP_W-1:0] amp0;
  logic [FREQ_W-1:0] freq0;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint corner_dot(longint unsigned cx, longint unsigned cy,
                                        longint ox, longint oy);
    int g;
    g = PERM_TAB[(PERM_TAB[cx & 255] + (cy & 255)) & 255] & 7;
    return GRAD_X[g] * ox + GRAD_Y[g] * oy;
  endfunction

  function automatic longint fade(longint t);
    longint sq;
    sq = (t * t) >>> FRAC_BITS;
    return (sq * (3 * 65536 - 2 * t)) >>> FRAC_BITS;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FRAC_BITS);
  endfunction

  function automatic longint octave_value(longint unsigned sx, longint unsigned sy,
                                          longint unsigned freq);
    longint unsigned px, py, x0, y0, x1, y1;
    longint u, v, fu, fv, top, bot, val;
    px = sx * freq;
    py = sy * freq;
    u = longint'((px >> 16) & 64'hFFFF);
    v = longint'((py >> 16) & 64'hFFFF);
    x0 = (px >> 32) & 255;
    y0 = (py >> 32) & 255;
    x1 = (x0 + 1) & 255;
    y1 = (y0 + 1) & 255;
    fu = fade(u);
    fv = fade(v);
    bot = blend(corner_dot(x0, y0, u, v), corner_dot(x1, y0, u - 65536, v), fu);
    top = blend(corner_dot(x0, y1, u, v - 65536),
                corner_dot(x1, y1, u - 65536, v - 65536), fu);
    val = blend(bot, top, fv);
    if (val > 65536) val = 65536;
    if (val < -65536) val = -65536;
    return val;
  endfunction

  function automatic logic signed [15:0] predict_noise(point_t p);
    longint unsigned sx, sy, amp, freq;
    longint total, amp_sum, q;
    int n;
    sx = longint'(p.x);
    sy = longint'(p.y);
    n = (octaves > 8) ? 8 : octaves;
    amp = amp0;
    freq = freq0;
    total = 0;
    amp_sum = 0;
    q = 0;
    for (int i = 0; i < n; i++) begin
      total += octave_value(sx, sy, freq) * longint'(amp);
      amp_sum += longint'(amp);
      amp = (amp * pers) >> 16;
      if (amp > AMP_MAX) amp = AMP_MAX;
      freq = (freq * lac) >> 16;
      if (freq > FREQ_MAX) freq = FREQ_MAX;
    end
    if (amp_sum > 0) begin
      q = (total * 32768) / (amp_sum * 65536);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
    end
    return q[15:0];
  endfunction

  // input word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        noise_q.push_back(predict_noise('{in_ch.x_coord, in_ch.y_coord}));
      if (in_ch.valid && !in_ch.ready) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        point_t p;
        p = point_q.pop_front();
        in_ch.x_coord <= p.x;
        in_ch.y_coord <= p.y;
        in_ch.valid <= 1'b1;
        gap_left <= calm ? 0 : $urandom_range(0, 14);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_trigger && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (noise_q.size() == 0) begin
          $display("%0t: unexpected noise word, expected none, actual %0d",
                   $time, out_ch.noise_value);
          errors++;
        end else begin
          logic signed [15:0] want;
          want = noise_q.pop_front();
          if (want !== out_ch.noise_value) begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                     $time, want, out_ch.noise_value);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          stall_left <= calm ? 0 : $urandom_range(0, 14);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_OCTAVE_COUNT: octaves = val[OCT_W-1:0];
      REG_PERSISTENCE: pers = val[PERS_W-1:0];
      REG_LACUNARITY: lac = val[LAC_W-1:0];
      REG_BASE_AMPLITUDE: amp0 = val[AMP_W-1:0];
      REG_BASE_FREQUENCY: freq0 = val[FREQ_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_all(int o, int p, int l, int a, int f);
    write_reg(REG_OCTAVE_COUNT, CFG_DATA_W'(o));
    write_reg(REG_PERSISTENCE, CFG_DATA_W'(p));
    write_reg(REG_LACUNARITY, CFG_DATA_W'(l));
    write_reg(REG_BASE_AMPLITUDE, CFG_DATA_W'(a));
    write_reg(REG_BASE_FREQUENCY, CFG_DATA_W'(f));
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (noise_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_point(logic [31:0] x, logic [31:0] y);
    point_q.push_back('{x, y});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      2: return {16'($urandom_range(0, 65535)), 16'h0};
      default: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  task automatic directed_points();
    add_point(32'h0, 32'h0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000);
    add_point(32'h7FFFFFFF, 32'h80000000);
    add_point(32'hFFFFFFFF, 32'h00000001);
    add_point(32'h00008000, 32'h00008000);
    add_point(32'h00FF8000, 32'h00FFC000);
    add_point(32'hFFFF0000, 32'h00010000);
    add_point(32'h0000FFFF, 32'hFFFF0001);
    add_point(32'h12345678, 32'hEDCBA987);
    add_point(32'hAAAAAAAA, 32'h55555555);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    octaves = OCT_RESET;
    pers = PERS_RESET;
    lac = LAC_RESET;
    amp0 = AMP_RESET;
    freq0 = FREQ_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed_points();
    drain();
    // octave count zero, count above the maximum, growth, ignored index
    write_reg(REG_OCTAVE_COUNT, 24'd0);
    add_point(32'h00018000, 32'h00024000);
    add_point(32'h7FFFFFFF, 32'h80000000);
    drain();
    set_all(15, 131071, 1048575, 524287, 24'hFFFFFF);
    write_reg(3'd7, 24'h0);
    write_reg(3'd5, 24'hFFFFFF);
    directed_points();
    drain();
    // zero amplitude sum and zero factors
    set_all(8, 0, 0, 0, 1);
    add_point(32'h00018000, 32'h00024000);
    drain();
    set_all(8, 0, 0, 65536, 1);
    directed_points();
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      int o;
      o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      set_all(o, $urandom_range(0, 65536), $urandom_range(0, 524288),
              $urandom_range(1, 262144),
              ($urandom_range(0, 1) ? $urandom_range(1, 16777215)
                                    : $urandom_range(4096, 262144)));
      calm = (ph % 3 == 1);
      if (ph == 4) hold_trigger = 1'b1;
      repeat (125) add_point(rand_coord(), rand_coord());
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire
